### design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared widths, defaults and result codes for the chained hash table search.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;

  localparam int BUCKETS_DEF      = 10;
  localparam int SEARCH_LIMIT_DEF = 10;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } cht_res_t;

endpackage

`default_nettype wire

### design/cht_if.sv
// ----------------------------------------------------------------------------
// cht_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_in_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface cht_out_if import cht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

`default_nettype wire

### design/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// Key modulo bucket count: fold the key bytes with their weights, then reduce
// the folded sum by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_mod import cht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic      [BKT_W-1:0] bucket
);

  // Byte weights 256^i mod BUCKETS; the weighted byte sum keeps the residue
  localparam int RES0  = 1 % BUCKETS;
  localparam int RES1  = 256 % BUCKETS;
  localparam int RES2  = 65536 % BUCKETS;
  localparam int RES3  = 16777216 % BUCKETS;
  localparam int SUM_W = 16;
  // Reciprocal of BUCKETS, exact for every SUM_W-bit dividend
  localparam int SHIFT = SUM_W + $clog2(BUCKETS);
  localparam int MAGIC = ((1 << SHIFT) + BUCKETS - 1) / BUCKETS;
  localparam int MAG_W = SUM_W + 1;

  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   busy_r;
  logic [BKT_W-1:0]       rem_r;
  logic [BKT_W-1:0]       rem_nxt;
  logic [SUM_W+MAG_W-1:0] prod;
  logic [SUM_W-1:0]       quot;
  logic [SUM_W-1:0]       rem_full;

  assign sum_nxt = SUM_W'(key[7:0])       * SUM_W'(RES0)
                 + SUM_W'(key[15:8])      * SUM_W'(RES1)
                 + SUM_W'(key[23:16])     * SUM_W'(RES2)
                 + SUM_W'(key[KEY_W-1:24]) * SUM_W'(RES3);

  assign prod     = sum_r * MAG_W'(MAGIC);
  assign quot     = SUM_W'(prod >> SHIFT);
  assign rem_full = sum_r - quot * SUM_W'(BUCKETS);
  assign rem_nxt  = rem_full[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      sum_r  <= sum_nxt;
    end else if (busy_r) begin
      busy_r <= 1'b0;
      rem_r  <= rem_nxt;
    end
  end

  assign done   = !busy_r;
  assign bucket = rem_r;

endmodule

`default_nettype wire

### design/cht_row.sv
// ----------------------------------------------------------------------------
// cht_row
// Bucket row update: parallel key compare for search, shift-in for insert.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_row import cht_pkg::*; #(
  parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF,
  localparam int FILL_W = $clog2(SEARCH_LIMIT + 1),
  localparam int ENT_W  = SEARCH_LIMIT * KEY_W,
  localparam int ROW_W  = FILL_W + ENT_W
) (
  input  wire logic             action,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [ROW_W-1:0] row,
  output logic      [ROW_W-1:0] new_row,
  output cht_res_t              res
);

  logic [FILL_W-1:0]      fill, fill_nxt;
  logic [ENT_W-1:0]       ent;
  logic [ENT_W+KEY_W-1:0] ent_sh;
  logic [SEARCH_LIMIT-1:0] hit;
  logic [POS_W-1:0]       pos;

  assign fill   = row[ROW_W-1 -: FILL_W];
  assign ent    = row[ENT_W-1:0];
  assign ent_sh = {ent, key};

  // Slot 0 (low bits) is the newest entry
  always_comb begin
    for (int i = 0; i < SEARCH_LIMIT; i++) begin
      hit[i] = (FILL_W'(i) < fill) && (ent[i*KEY_W +: KEY_W] == key);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = SEARCH_LIMIT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pos = POS_W'(i + 1);
      end
    end
  end

  assign fill_nxt = (fill < FILL_W'(SEARCH_LIMIT)) ? fill + FILL_W'(1)
                                                   : FILL_W'(SEARCH_LIMIT);

  always_comb begin
    new_row = {fill_nxt, ent_sh[ENT_W-1:0]};
    if (action == ACT_INSERT) begin
      res.status   = ST_INSERTED;
      res.position = '0;
    end else if (fill == '0) begin
      res.status   = ST_EMPTY;
      res.position = '0;
    end else if (hit != '0) begin
      res.status   = ST_FOUND;
      res.position = pos;
    end else begin
      res.status   = ST_MISSING;
      res.position = '0;
    end
  end

endmodule

`default_nettype wire

### design/chained_hash_table_search.sv
// ----------------------------------------------------------------------------
// chained_hash_table_search
// Hash table with separate chaining: insert a key at the newest end of its
// bucket, or search the bucket newest-first and report the match position.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Fields              Transaction meaning
//   in_ch     in   action, key         insert (0) or search (1) one key
//   out_ch    out  status, position    one result per request
//
// From acceptance to a valid result each request takes these steps: the
// acceptance edge latches the weighted sum of the key bytes; then the sum
// is reduced to the bucket index, the index is handed to the row read, the
// row is read, and it is compared and, on an insert, written back. Requests
// are handled one at a time: the next one is taken in the cycle after the
// result registers, so a new request is never accepted before the last is done.
// Reset clears the per-bucket valid bits, so every bucket reads as empty; no
// clearing pass is needed. A stalled result holds in the output register
// while the next request is accepted and worked up to its row compare.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_search import cht_pkg::*; #(
  parameter int BUCKETS      = BUCKETS_DEF,
  parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cht_in_if.sink    in_ch,
  cht_out_if.source out_ch
);

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FILL_W = $clog2(SEARCH_LIMIT + 1);
  localparam int ROW_W  = FILL_W + SEARCH_LIMIT * KEY_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_CMP
  } state_t;

  state_t              state_r;
  logic                act_r;
  logic [KEY_W-1:0]    key_r;
  logic [BUCKETS-1:0]  bkt_valid_r;
  logic                out_valid_r;
  cht_res_t            out_res_r;

  logic                in_fire;
  logic                mod_done;
  logic [BKT_W-1:0]    bucket;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    cur_row;
  logic [ROW_W-1:0]    new_row;
  cht_res_t            row_res;
  logic                res_load;
  logic                commit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Bucket index from the key: byte fold, then reciprocal reduction
  cht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .key    (in_ch.key),
    .done   (mod_done),
    .bucket (bucket)
  );

  // One row per bucket: fill count on top, entries below, slot 0 newest
  cht_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_rows (
    .clk     (clk),
    .we      (commit),
    .waddr   (bucket),
    .wdata   (new_row),
    .re      (state_r == S_RD),
    .raddr   (bucket),
    .rdata_r (rd_row)
  );

  // A bucket never written since reset reads as empty
  assign cur_row = bkt_valid_r[bucket] ? rd_row : {FILL_W'(0), rd_row[ROW_W-FILL_W-1:0]};

  cht_row #(.SEARCH_LIMIT(SEARCH_LIMIT)) u_row (
    .action  (act_r),
    .key     (key_r),
    .row     (cur_row),
    .new_row (new_row),
    .res     (row_res)
  );

  // Finish the row step only once the output register is free; only an
  // insert writes its row back
  assign res_load = (state_r == S_CMP) && (!out_valid_r || out_ch.ready);
  assign commit   = res_load && (act_r == ACT_INSERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bkt_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the old one once the sink takes it
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r   <= in_ch.action;
            key_r   <= in_ch.key;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Hold here while an earlier result still waits
          if (res_load) begin
            out_res_r <= row_res;
            if (act_r == ACT_INSERT) begin
              bkt_valid_r[bucket] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_res_r.status;
  assign out_ch.position = out_res_r.position;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chained_hash_table_search. It drives insert and
// search transactions under random idling and back-pressure. A scoreboard
// keeps its own copy of every bucket chain, predicts each result, and checks
// it field by field in order.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let the block settle once the last result has been taken
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 112;
  localparam int POOL_DEPTH     = 40;
  localparam int SMALL_KEY_MAX  = 59;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the bucket chains and holds the results still owed.
  // --------------------------------------------------------------------------
  class hash_chain_scoreboard;
    logic [KEY_W-1:0] chain_keys [BUCKETS_DEF][SEARCH_LIMIT_DEF];
    int unsigned      chain_fill [BUCKETS_DEF];
    cht_res_t         owed_results [$];
    int unsigned      mismatches;

    function new();
      foreach (chain_fill[b]) chain_fill[b] = 0;
      foreach (chain_keys[b, s]) chain_keys[b][s] = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    task report(string msg);
      $display("ERROR %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    // Apply one accepted request to the chains and queue its result.
    function void note_request(logic act, logic [KEY_W-1:0] key);
      int unsigned bucket;
      int unsigned depth;
      cht_res_t    res;
      bucket       = int'(key) % BUCKETS_DEF;
      depth        = chain_fill[bucket];
      res.status   = ST_MISSING;
      res.position = '0;
      if (act == ACT_INSERT) begin
        // Push the key in at the newest end; the oldest falls off a full chain
        for (int s = SEARCH_LIMIT_DEF - 1; s > 0; s--) begin
          chain_keys[bucket][s] = chain_keys[bucket][s-1];
        end
        chain_keys[bucket][0] = key;
        if (depth < SEARCH_LIMIT_DEF) chain_fill[bucket] = depth + 1;
        res.status = ST_INSERTED;
      end else if (depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        for (int s = 0; s < depth; s++) begin
          if (chain_keys[bucket][s] == key) begin
            res.status   = ST_FOUND;
            res.position = POS_W'(s + 1);
            break;
          end
        end
      end
      owed_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest one owed.
    task check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position);
      cht_res_t exp_res;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d position=%0d", status, position));
      end else begin
        exp_res = owed_results.pop_front();
        if (status !== exp_res.status) begin
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
        end
        if (position !== exp_res.position) begin
          report($sformatf("position %0d, expected %0d", position, exp_res.position));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  cht_in_if  in_ch ();
  cht_out_if out_ch ();

  chained_hash_table_search #(
    .BUCKETS      (BUCKETS_DEF),
    .SEARCH_LIMIT (SEARCH_LIMIT_DEF)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hash_chain_scoreboard sb = new();

  int unsigned      sender_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      quiet_cycles;
  logic [KEY_W-1:0] key_pool [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Randomly stall the result channel; the stall rate is set per phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor both channels at the rising edge, score transactions, and run
  // the watchdog. Results are checked before the new request is noted; a
  // request never produces its result in the cycle it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.position);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.action, in_ch.key);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one request. Call at a falling edge; return at the falling edge
  // after the transaction, with valid still high so the next one can follow
  // back to back.
  task send_request(input logic act, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= key;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (act == ACT_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // Hold the request channel idle until every owed result has been taken.
  task drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Favor keys that collide: a small range fills and overflows chains, and
  // recent inserts give hits at every depth. Wide keys exercise all bits.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return KEY_W'($urandom_range(SMALL_KEY_MAX));
    end else if (pick < 75 && key_pool.size() != 0) begin
      return key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      return KEY_W'($urandom);
    end
  endfunction

  initial begin
    int unsigned idle_plan  [4] = '{0, 68, 0, 19};
    int unsigned stall_plan [4] = '{0, 0, 68, 19};

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_INSERT;
    in_ch.key       = '0;
    out_ch.ready    = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    quiet_cycles    = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: search an untouched bucket, then the key extremes
    send_request(ACT_SEARCH, KEY_W'(5));
    send_request(ACT_INSERT, '0);
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_SEARCH, KEY_MAX);
    // Same bucket as the largest key, but absent
    send_request(ACT_SEARCH, KEY_W'(17));
    // Duplicate key: the newest copy answers
    send_request(ACT_INSERT, '0);
    send_request(ACT_SEARCH, '0);
    // Overflow one chain: eleven inserts push the first key out
    for (int k = 0; k <= SEARCH_LIMIT_DEF; k++) begin
      send_request(ACT_INSERT, KEY_W'(3 + 10 * k));
    end
    send_request(ACT_SEARCH, KEY_W'(3));
    send_request(ACT_SEARCH, KEY_W'(13));
    send_request(ACT_SEARCH, KEY_W'(3 + 10 * SEARCH_LIMIT_DEF));

    // Random phases under varying idle and stall rates; between phases,
    // hold off the sender until every owed result has come back
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      sender_idle_pct = idle_plan[ph];
      recv_stall_pct  = stall_plan[ph];
      @(negedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request($urandom_range(1) ? ACT_SEARCH : ACT_INSERT, pick_key());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
